// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the RTL top level.
// Each macro wraps one concurrent property with an async reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rstn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ----- rtl/cgft_pkg.sv -----
// Shared types and constants for the cycloid foot trajectory unit.
// No dependencies.
`default_nettype none
package cgft_pkg;
	localparam int LEG_COUNT         = 6;
	localparam int LEG_W             = 3;
	localparam int CFG_W             = 48;
	localparam int PPS_W             = 11;
	localparam int STEP_W            = 11;
	localparam int HEAD_W            = 16;
	localparam int DEF_COORD_WIDTH   = 16;
	localparam int DEF_ANGLE_WIDTH   = 16;
	localparam int DELTA_W           = 24;

	localparam logic [PPS_W-1:0] PPS_RESET = 11'd32;

	// sine polynomial, Q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [16:0] SIN_B = 17'd42048;
	localparam logic [16:0] SIN_C = 17'd4640;
	localparam logic signed [15:0] INV_2PI = 16'sd10430;
	localparam logic signed [15:0] INV_4PI = 16'sd5215;

	typedef enum logic [2:0] {
		REG_LEG0_HOME,
		REG_LEG1_HOME,
		REG_LEG2_HOME,
		REG_LEG3_HOME,
		REG_LEG4_HOME,
		REG_LEG5_HOME,
		REG_GAIT_DIMS,
		REG_POINTS_PER_STEP
	} cfg_reg_t;

	typedef struct packed {
		logic first;
		logic sel;
	} tag_t;

	typedef logic [17:0] phase_t;
	typedef logic signed [17:0] sine_t;
	typedef logic [16:0] kq_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
endpackage
`default_nettype wire

// ----- rtl/cycloid_gait_foot_trajectory_unit.sv -----
// Cycloid tripod-gait foot trajectory unit, top level.
// Uses cgft_pkg, cgft_div, cgft_sine, cgft_scale, cgft_legout, assert_macros.svh.
//
// Input channel (in_valid/in_stall): one beat per interpolation point
// (step_index, heading, tripod_select). Output channel (out_valid/out_stall):
// six beats per point, legs 0..5 in order, last_leg set on leg 5.
// Config port: cfg_we writes cfg_data to register cfg_index;
// write only while no point is in flight.
// Pipeline: eleven stages (input decode, three divider stages for
// the phase, four sine stages, three scaling stages) plus the output stage;
// the first leg beat shows once the point has passed all eleven.
// The output stage sets the point rate, as it spends six leg beats on
// each point. Up to 11 points queue in the pipeline behind it, so
// in_stall rises only when every stage holds a point.
// Reset clears all valid bits and the config registers (homes and gait
// dimensions to 0, points per step to 32). While out_stall is high the
// current leg beat holds and stages fill until in_stall asserts; nothing
// is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"
module cycloid_gait_foot_trajectory_unit #(
	parameter int COORD_WIDTH = cgft_pkg::DEF_COORD_WIDTH,
	parameter int ANGLE_WIDTH = cgft_pkg::DEF_ANGLE_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [cgft_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [cgft_pkg::STEP_W-1:0]   step_index,
	input  wire logic [cgft_pkg::HEAD_W-1:0]   heading,
	input  wire logic                          tripod_select,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [cgft_pkg::LEG_W-1:0]         leg_number,
	output logic signed [COORD_WIDTH-1:0]      foot_x,
	output logic signed [COORD_WIDTH-1:0]      foot_y,
	output logic signed [COORD_WIDTH-1:0]      foot_z,
	output logic                               last_leg
);
	import cgft_pkg::*;

	localparam int NSTG   = 11;
	localparam int AW_EFF = (ANGLE_WIDTH < HEAD_W) ? ANGLE_WIDTH : HEAD_W;

	// config registers
	logic [LEG_COUNT-1:0][47:0] home_q;
	logic [47:0]                dims_q;
	logic [PPS_W-1:0]           pps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q <= '0;
			dims_q <= '0;
			pps_q  <= PPS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIT_DIMS:       dims_q <= cfg_data;
				REG_POINTS_PER_STEP: pps_q  <= cfg_data[PPS_W-1:0];
				default:             home_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	// stage load enables, bubbles collapse
	logic [NSTG:1]   stage_vld_q;
	logic [NSTG+1:1] ld;
	logic            ser_load;

	always_comb begin
		ld[NSTG+1] = ser_load;
		for (int i = NSTG; i >= 1; i--)
			ld[i] = !stage_vld_q[i] || ld[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (ld[1])
				stage_vld_q[1] <= in_valid;
			for (int i = 2; i <= NSTG; i++)
				if (ld[i])
					stage_vld_q[i] <= stage_vld_q[i-1];
		end
	end

	assign in_stall = !ld[1];

	// stage 1: step count, fold, heading phase
	logic [10:0] n_pts, half, step_c;
	logic [11:0] num;
	logic        first;
	logic [31:0] ang32;

	always_comb begin
		n_pts  = {pps_q[10:1], 1'b0};
		if (n_pts == 11'd0)
			n_pts = 11'd2;
		half   = {1'b0, n_pts[10:1]};
		step_c = (step_index > n_pts) ? n_pts : step_index;
		first  = (step_c <= half);
		num    = first ? ({1'b0, step_c} + {1'b0, half})
			: (12'({half, 1'b0}) + {1'b0, half} - {1'b0, step_c});
		ang32  = 32'(heading[AW_EFF-1:0]) << (32 - ANGLE_WIDTH);
	end

	logic [10:0] num_s1, n_s1;
	tag_t        tag_s1;
	phase_t      ang_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			num_s1    <= num[10:0];
			n_s1      <= n_pts;
			tag_s1    <= '{first: first, sel: tripod_select};
			ang_s1    <= ang32[31:14];
		end
	end

	// stages 2..4
	kq_t    kq_s4;
	tag_t   tag_s4;
	phase_t ang_s4;

	cgft_div u_div (
		.clk        (clk),
		.en         (ld[4:2]),
		.num        (num_s1),
		.n_pts      (n_s1),
		.tag        (tag_s1),
		.angle      (ang_s1),
		.quot       (kq_s4),
		.quot_tag   (tag_s4),
		.quot_angle (ang_s4)
	);

	// stages 5..8
	sine_t s1_s8, s2_s8, cs_s8, sn_s8;

	cgft_sine u_sin_k1 (.clk(clk), .en(ld[8:5]), .ph({kq_s4[15:0], 2'b00}), .sine(s1_s8));
	cgft_sine u_sin_k2 (.clk(clk), .en(ld[8:5]), .ph({kq_s4[14:0], 3'b000}), .sine(s2_s8));
	cgft_sine u_cos_h  (.clk(clk), .en(ld[8:5]), .ph(ang_s4 + 18'h10000), .sine(cs_s8));
	cgft_sine u_sin_h  (.clk(clk), .en(ld[8:5]), .ph(ang_s4), .sine(sn_s8));

	kq_t  kq_s5, kq_s6, kq_s7, kq_s8;
	tag_t tag_s5, tag_s6, tag_s7, tag_s8;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			kq_s5  <= kq_s4;
			tag_s5 <= tag_s4;
		end
		if (ld[6]) begin
			kq_s6  <= kq_s5;
			tag_s6 <= tag_s5;
		end
		if (ld[7]) begin
			kq_s7  <= kq_s6;
			tag_s7 <= tag_s6;
		end
		if (ld[8]) begin
			kq_s8  <= kq_s7;
			tag_s8 <= tag_s7;
		end
	end

	// stages 9..11
	delta_t dx_s11, dy_s11, dz_s11;
	tag_t   tag_s11;

	cgft_scale u_scale (
		.clk  (clk),
		.en   (ld[11:9]),
		.kq   (kq_s8),
		.s1   (s1_s8),
		.s2   (s2_s8),
		.cs   (cs_s8),
		.sn   (sn_s8),
		.tag  (tag_s8),
		.span (dims_q[15:0]),
		.lift (dims_q[31:16]),
		.dx   (dx_s11),
		.dy   (dy_s11),
		.dz   (dz_s11),
		.dtag (tag_s11)
	);

	cgft_legout #(.COORD_WIDTH(COORD_WIDTH)) u_legout (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail_valid (stage_vld_q[NSTG]),
		.tag        (tag_s11),
		.dx         (dx_s11),
		.dy         (dy_s11),
		.dz         (dz_s11),
		.homes      (home_q),
		.body       ($signed(dims_q[47:32])),
		.out_stall  (out_stall),
		.load       (ser_load),
		.out_valid  (out_valid),
		.leg_number (leg_number),
		.foot_x     (foot_x),
		.foot_y     (foot_y),
		.foot_z     (foot_z),
		.last_leg   (last_leg)
	);

	// input is held back only when the output side is occupied
	`ASSERT_SAME(a_stall_needs_out, clk, arst_n, in_valid && in_stall, out_valid)
	// legs of one point go out in order with no gaps
	`ASSERT_NEXT(a_leg_order, clk, arst_n, out_valid && !out_stall && !last_leg,
		out_valid && leg_number == LEG_W'($past(leg_number) + LEG_W'(1)))
	// an empty output stage always restarts at leg 0
	`ASSERT_SAME(a_idle_leg0, clk, arst_n, !out_valid, leg_number == '0)
endmodule
`default_nettype wire

// ----- rtl/cgft_div.sv -----
// Three-stage restoring divider: phase k = floor(num * 2^16 / n), 17 quotient bits.
// Uses cgft_pkg; carries the item tag and heading phase alongside.
`default_nettype none
module cgft_div (
	input  wire logic             clk,
	input  wire logic [2:0]       en,
	input  wire logic [10:0]      num,
	input  wire logic [10:0]      n_pts,
	input  wire cgft_pkg::tag_t   tag,
	input  wire cgft_pkg::phase_t angle,
	output cgft_pkg::kq_t         quot,
	output cgft_pkg::tag_t        quot_tag,
	output cgft_pkg::phase_t      quot_angle
);
	import cgft_pkg::*;

	logic [11:0] ra, rb, rc;
	logic [5:0]  qa, qb;
	logic [4:0]  qc;
	logic [11:0] nx;

	logic [10:0] r_s2, r_s3;
	logic [10:0] n_s2, n_s3;
	logic [5:0]  q_s2;
	logic [11:0] q_s3;
	tag_t        tag_s2, tag_s3, tag_s4;
	phase_t      ang_s2, ang_s3, ang_s4;
	kq_t         kq_s4;

	assign nx = {1'b0, n_pts};

	// bit 16 (no shift) then bits 15..11
	always_comb begin
		ra = {1'b0, num};
		qa = '0;
		for (int i = 0; i < 6; i++) begin
			if (i != 0)
				ra = {ra[10:0], 1'b0};
			if (ra >= nx) begin
				ra = ra - nx;
				qa = {qa[4:0], 1'b1};
			end else begin
				qa = {qa[4:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s2   <= ra[10:0];
			q_s2   <= qa;
			n_s2   <= n_pts;
			tag_s2 <= tag;
			ang_s2 <= angle;
		end
	end

	// bits 10..5
	always_comb begin
		rb = {1'b0, r_s2};
		qb = '0;
		for (int i = 0; i < 6; i++) begin
			rb = {rb[10:0], 1'b0};
			if (rb >= {1'b0, n_s2}) begin
				rb = rb - {1'b0, n_s2};
				qb = {qb[4:0], 1'b1};
			end else begin
				qb = {qb[4:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			r_s3   <= rb[10:0];
			q_s3   <= {q_s2, qb};
			n_s3   <= n_s2;
			tag_s3 <= tag_s2;
			ang_s3 <= ang_s2;
		end
	end

	// bits 4..0
	always_comb begin
		rc = {1'b0, r_s3};
		qc = '0;
		for (int i = 0; i < 5; i++) begin
			rc = {rc[10:0], 1'b0};
			if (rc >= {1'b0, n_s3}) begin
				rc = rc - {1'b0, n_s3};
				qc = {qc[3:0], 1'b1};
			end else begin
				qc = {qc[3:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			kq_s4  <= {q_s3, qc};
			tag_s4 <= tag_s3;
			ang_s4 <= ang_s3;
		end
	end

	assign quot       = kq_s4;
	assign quot_tag   = tag_s4;
	assign quot_angle = ang_s4;
endmodule
`default_nettype wire

// ----- rtl/cgft_sine.sv -----
// Four-stage polynomial sine of a turn fraction, one multiply per stage.
// Uses cgft_pkg for the coefficients; result is Q16, clamped to +-1.
`default_nettype none
module cgft_sine (
	input  wire logic             clk,
	input  wire logic [3:0]       en,
	input  wire cgft_pkg::phase_t ph,
	output cgft_pkg::sine_t       sine
);
	import cgft_pkg::*;

	logic [16:0] x;
	logic [33:0] xx;
	logic [29:0] cx;
	logic [32:0] bx;
	logic [33:0] ax;
	logic [17:0] mag;
	logic [16:0] clamped;

	logic [1:0]  q_s1, q_s2, q_s3;
	logic [16:0] x_s1, x_s2, x_s3;
	logic [16:0] x2_s1, x2_s2;
	logic [16:0] b_s2;
	logic [16:0] a_s3;
	sine_t       y_s4;

	// odd quadrants are mirrored
	assign x  = ph[16] ? (17'd65536 - {1'b0, ph[15:0]}) : {1'b0, ph[15:0]};
	assign xx = x * x;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s1  <= ph[17:16];
			x_s1  <= x;
			x2_s1 <= xx[32:16];
		end
	end

	assign cx = SIN_C[12:0] * x2_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s2  <= q_s1;
			x_s2  <= x_s1;
			x2_s2 <= x2_s1;
			b_s2  <= SIN_B - {3'b0, cx[29:16]};
		end
	end

	assign bx = b_s2[15:0] * x2_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			q_s3 <= q_s2;
			x_s3 <= x_s2;
			a_s3 <= SIN_A - bx[32:16];
		end
	end

	assign ax      = a_s3 * x_s3;
	assign mag     = ax[33:16];
	assign clamped = (mag > 18'd65536) ? 17'd65536 : mag[16:0];

	always_ff @(posedge clk) begin
		if (en[3])
			y_s4 <= q_s3[1] ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
	end

	assign sine = y_s4;
endmodule
`default_nettype wire

// ----- rtl/cgft_scale.sv -----
// Cycloid terms and stride/lift scaling in three stages: c, d, then
// products with u and hq, then rounding to the per-item dx, dy, dz.
// Uses cgft_pkg.
`default_nettype none
module cgft_scale (
	input  wire logic            clk,
	input  wire logic [2:0]      en,
	input  wire cgft_pkg::kq_t   kq,
	input  wire cgft_pkg::sine_t s1,
	input  wire cgft_pkg::sine_t s2,
	input  wire cgft_pkg::sine_t cs,
	input  wire cgft_pkg::sine_t sn,
	input  wire cgft_pkg::tag_t  tag,
	input  wire logic [15:0]     span,
	input  wire logic [15:0]     lift,
	output cgft_pkg::delta_t     dx,
	output cgft_pkg::delta_t     dy,
	output cgft_pkg::delta_t     dz,
	output cgft_pkg::tag_t       dtag
);
	import cgft_pkg::*;

	logic signed [33:0] m1, m2;
	logic [33:0]        a1, a2;
	logic [17:0]        r1, r2;
	logic signed [18:0] c, d;
	logic signed [34:0] px, py;

	logic signed [18:0] c_s9, d_s9;
	logic signed [34:0] px_s9, py_s9;
	tag_t               tag_s9, tag_s10, tag_s11;

	logic signed [18:0] u;
	logic signed [19:0] hq;
	logic signed [53:0] mx_s10, my_s10;
	logic signed [36:0] mz_s10;

	logic [53:0] ax, ay;
	logic [36:0] az;
	delta_t      dx_s11, dy_s11, dz_s11;

	assign m1 = s1 * INV_2PI;
	assign m2 = s2 * INV_4PI;
	assign a1 = (m1[33] ? 34'(-m1) : 34'(m1)) + 34'd32768;
	assign a2 = (m2[33] ? 34'(-m2) : 34'(m2)) + 34'd32768;
	assign r1 = a1[33:16];
	assign r2 = a2[33:16];
	assign c  = $signed({2'b0, kq}) -
		(m1[33] ? -$signed({1'b0, r1}) : $signed({1'b0, r1}));
	assign d  = $signed({2'b0, kq}) -
		(m2[33] ? -$signed({1'b0, r2}) : $signed({1'b0, r2}));
	assign px = cs * $signed({1'b0, span});
	assign py = sn * $signed({1'b0, span});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			c_s9   <= c;
			d_s9   <= d;
			px_s9  <= px;
			py_s9  <= py;
			tag_s9 <= tag;
		end
	end

	assign u  = c_s9 - 19'sd32768;
	assign hq = 20'sd131072 - $signed({d_s9, 1'b0});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx_s10  <= px_s9 * u;
			my_s10  <= py_s9 * u;
			mz_s10  <= $signed({1'b0, lift}) * hq;
			tag_s10 <= tag_s9;
		end
	end

	// round to nearest, ties away from zero
	assign ax = (mx_s10[53] ? 54'(-mx_s10) : 54'(mx_s10)) + 54'h0_8000_0000;
	assign ay = (my_s10[53] ? 54'(-my_s10) : 54'(my_s10)) + 54'h0_8000_0000;
	assign az = (mz_s10[36] ? 37'(-mz_s10) : 37'(mz_s10)) + 37'd32768;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dx_s11  <= mx_s10[53] ? -$signed({2'b0, ax[53:32]}) : $signed({2'b0, ax[53:32]});
			dy_s11  <= my_s10[53] ? -$signed({2'b0, ay[53:32]}) : $signed({2'b0, ay[53:32]});
			dz_s11  <= mz_s10[36] ? -$signed({3'b0, az[36:16]}) : $signed({3'b0, az[36:16]});
			tag_s11 <= tag_s10;
		end
	end

	assign dx   = dx_s11;
	assign dy   = dy_s11;
	assign dz   = dz_s11;
	assign dtag = tag_s11;
endmodule
`default_nettype wire

// ----- rtl/cgft_legout.sv -----
// Output stage: holds one item's offsets and emits six leg beats,
// adding each leg's home position and saturating. Uses cgft_pkg.
`default_nettype none
module cgft_legout #(
	parameter int COORD_WIDTH = cgft_pkg::DEF_COORD_WIDTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    tail_valid,
	input  wire cgft_pkg::tag_t                          tag,
	input  wire cgft_pkg::delta_t                        dx,
	input  wire cgft_pkg::delta_t                        dy,
	input  wire cgft_pkg::delta_t                        dz,
	input  wire logic [cgft_pkg::LEG_COUNT-1:0][47:0]    homes,
	input  wire logic signed [15:0]                      body,
	input  wire logic                                    out_stall,
	output logic                                         load,
	output logic                                         out_valid,
	output logic [cgft_pkg::LEG_W-1:0]                   leg_number,
	output logic signed [COORD_WIDTH-1:0]                foot_x,
	output logic signed [COORD_WIDTH-1:0]                foot_y,
	output logic signed [COORD_WIDTH-1:0]                foot_z,
	output logic                                         last_leg
);
	import cgft_pkg::*;

	localparam int SUM_W = 26;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	logic             busy_q;
	logic [LEG_W-1:0] leg_q;
	tag_t             tag_q;
	delta_t           dx_q, dy_q, dz_q;

	logic [47:0]             h;
	logic                    in_a, lifted, beat;
	logic signed [SUM_W-1:0] sx, sy, sz;

	assign beat     = busy_q && !out_stall;
	assign last_leg = (leg_q == LEG_W'(LEG_COUNT - 1));
	assign load     = !busy_q || (beat && last_leg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			leg_q  <= '0;
		end else if (load) begin
			busy_q <= tail_valid;
			leg_q  <= '0;
		end else if (beat) begin
			leg_q  <= leg_q + LEG_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && tail_valid) begin
			tag_q <= tag;
			dx_q  <= dx;
			dy_q  <= dy;
			dz_q  <= dz;
		end
	end

	assign h      = homes[leg_q];
	assign in_a   = tag_q.sel ? !leg_q[0] : leg_q[0];
	assign lifted = tag_q.first ? in_a : !in_a;

	always_comb begin
		sx = SUM_W'($signed(h[15:0])) + (in_a ? SUM_W'(dx_q) : -SUM_W'(dx_q));
		sy = SUM_W'($signed(h[31:16])) + (in_a ? SUM_W'(dy_q) : -SUM_W'(dy_q));
		sz = SUM_W'($signed(h[47:32])) + (lifted ? SUM_W'(dz_q) : '0) + SUM_W'(body);
	end

	always_comb begin
		foot_x = (sx > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
			(sx < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sx);
		foot_y = (sy > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
			(sy < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sy);
		foot_z = (sz > SAT_HI) ? COORD_WIDTH'(SAT_HI) :
			(sz < SAT_LO) ? COORD_WIDTH'(SAT_LO) : COORD_WIDTH'(sz);
	end

	assign out_valid  = busy_q;
	assign leg_number = leg_q;
endmodule
`default_nettype wire

// ----- sim/cycloid_gait_foot_trajectory_unit_tb.sv -----
// Testbench for the cycloid tripod-gait foot trajectory unit.
// Depends on cgft_pkg and the RTL top; drives random points and checks six leg beats each.
`default_nettype none
module cycloid_gait_foot_trajectory_unit_tb;
	import cgft_pkg::*;

	typedef struct packed {
		logic [2:0] leg;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] fz;
		logic last;
	} leg_pos_t;

	typedef struct {
		logic [10:0] stp;
		logic [15:0] hdg;
		logic sel;
		logic chk;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] z0;
	} pt_row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;
	logic in_valid, in_stall;
	logic [10:0] step_index;
	logic [15:0] heading;
	logic tripod_select;
	logic out_valid, out_stall;
	logic [2:0] leg_number;
	logic signed [15:0] foot_x, foot_y, foot_z;
	logic last_leg;

	cycloid_gait_foot_trajectory_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.step_index(step_index), .heading(heading), .tripod_select(tripod_select),
		.out_valid(out_valid), .out_stall(out_stall), .leg_number(leg_number),
		.foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z), .last_leg(last_leg)
	);

	logic [47:0] home_reg [6];
	logic [47:0] dims_reg;
	logic [10:0] pps_reg;
	leg_pos_t expected_legs[$];
	int errors = 0;
	int beats_seen = 0;
	int points_sent = 0;
	longint cycles = 0;
	bit calm = 0;	// long stretch with no idling

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("timeout at %0t", $time);
			$display("cycloid_gait_foot_trajectory_unit_tb: FAIL");
			$finish;
		end
	end

	function automatic longint round_shift(longint v, int s);
		longint h;
		h = longint'(1) <<< (s - 1);
		if (v >= 0)
			return (v + h) >>> s;
		return -((-v + h) >>> s);
	endfunction

	function automatic longint sine_of_turn(logic [31:0] p);
		longint f, x, x2, t;
		f = p[29:14];
		x = p[30] ? 65536 - f : f;
		x2 = (x * x) >> 16;
		t = (4640 * x2) >> 16;
		t = 42048 - t;
		t = (t * x2) >> 16;
		t = 102944 - t;
		t = (t * x) >> 16;
		if (t > 65536)
			t = 65536;
		return p[31] ? -t : t;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic longint sx16(logic [15:0] v);
		return longint'(signed'(v));
	endfunction

	task automatic predict_feet(logic [10:0] stp, logic [15:0] hdg, logic sel);
		longint n, hlf, s, num, kq, c, u, d, hq, dx, dy, dz, cs, sn, x, y, z;
		logic [31:0] ph;
		logic first, in_a, lifted;
		leg_pos_t e;
		n = pps_reg & 11'h7FE;
		if (n < 2)
			n = 2;
		hlf = n >> 1;
		s = stp;
		if (s > n)
			s = n;
		first = s <= hlf;
		num = first ? s + hlf : 3 * hlf - s;
		kq = (num << 16) / n;
		ph = 32'(kq << 16);
		c = kq - round_shift(sine_of_turn(ph) * 10430, 16);
		u = c - 32768;
		ph = 32'(kq << 17);
		d = kq - round_shift(sine_of_turn(ph) * 5215, 16);
		hq = 131072 - 2 * d;
		cs = sine_of_turn({hdg, 16'h0} + 32'h4000_0000);
		sn = sine_of_turn({hdg, 16'h0});
		dx = round_shift(cs * longint'(dims_reg[15:0]) * u, 32);
		dy = round_shift(sn * longint'(dims_reg[15:0]) * u, 32);
		dz = round_shift(longint'(dims_reg[31:16]) * hq, 16);
		for (int i = 0; i < 6; i++) begin
			in_a = sel ? (i % 2 == 0) : (i % 2 == 1);
			lifted = first ? in_a : !in_a;
			x = sx16(home_reg[i][15:0]) + (in_a ? dx : -dx);
			y = sx16(home_reg[i][31:16]) + (in_a ? dy : -dy);
			z = sx16(home_reg[i][47:32]) + (lifted ? dz : 0) + sx16(dims_reg[47:32]);
			e.leg = 3'(i);
			e.fx = clamp16(x);
			e.fy = clamp16(y);
			e.fz = clamp16(z);
			e.last = (i == 5);
			expected_legs.push_back(e);
		end
	endtask

	// output side: stall at random, check each accepted beat
	always @(negedge clk)
		out_stall <= !calm && arst_n && ($urandom_range(99) < 23);

	always @(posedge clk) begin
		leg_pos_t e;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (expected_legs.size() == 0) begin
				$display("%0t: unexpected beat leg %0d", $time, leg_number);
				errors++;
			end else begin
				e = expected_legs.pop_front();
				if (e.leg !== leg_number || e.fx !== foot_x || e.fy !== foot_y ||
						e.fz !== foot_z || e.last !== last_leg) begin
					$display("%0t: expected leg %0d x %0d y %0d z %0d last %0b", $time,
						e.leg, $signed(e.fx), $signed(e.fy), $signed(e.fz), e.last);
					$display("%0t: actual   leg %0d x %0d y %0d z %0d last %0b", $time,
						leg_number, foot_x, foot_y, foot_z, last_leg);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == REG_POINTS_PER_STEP)
			pps_reg = val[10:0];
		else if (idx == REG_GAIT_DIMS)
			dims_reg = val;
		else
			home_reg[idx] = val;
	endtask

	// drops valid, then waits until every expected beat has come out
	task automatic wait_drained();
		in_valid <= 0;
		while (expected_legs.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// sends one point at the falling edge; waits until it is taken
	// valid stays high afterwards so points can follow back to back
	task automatic send_point(logic [10:0] stp, logic [15:0] hdg, logic sel);
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		step_index <= stp;
		heading <= hdg;
		tripod_select <= sel;
		predict_feet(stp, hdg, sel);
		points_sent++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_points(int count, int max_step);
		for (int j = 0; j < count; j++)
			send_point($urandom_range(max_step), $urandom, $urandom_range(1));
	endtask

	pt_row_t dir_tab [] = '{
		// after reset all homes and dims are zero: every foot at the origin
		'{11'd0,    16'h0000, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0},
		'{11'd16,   16'h4000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
		'{11'd32,   16'hFFFF, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0},
		'{11'd2047, 16'h8000, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0},
		'{11'd1024, 16'hC000, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0}
	};
	pt_row_t dir_tab2 [] = '{
		'{11'd0,    16'h0000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd8,    16'h2000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd16,   16'h4000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd17,   16'h6000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd24,   16'h8000, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd31,   16'hA000, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd32,   16'hFFFF, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd2047, 16'h5555, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0},
		'{11'd1,    16'h0001, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0}
	};

	initial begin
		leg_pos_t e;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_LEG0_HOME;
		cfg_data = '0;
		in_valid = 0;
		step_index = '0;
		heading = '0;
		tripod_select = 0;
		out_stall = 0;
		for (int i = 0; i < 6; i++)
			home_reg[i] = '0;
		dims_reg = '0;
		pps_reg = PPS_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset values: typed-in expectation checked against predictor too
		foreach (dir_tab[r]) begin
			send_point(dir_tab[r].stp, dir_tab[r].hdg, dir_tab[r].sel);
			if (dir_tab[r].chk) begin
				for (int i = 0; i < 6; i++) begin
					e = expected_legs[expected_legs.size() - 6 + i];
					if (e.fx !== dir_tab[r].x0 || e.fy !== dir_tab[r].y0 ||
							e.fz !== dir_tab[r].z0) begin
						$display("%0t: table row %0d disagrees with predictor", $time, r);
						errors++;
					end
				end
			end
		end
		wait_drained();

		// typical geometry
		write_reg(REG_LEG0_HOME, {16'd0, 16'd1600, 16'd1600});
		write_reg(REG_LEG1_HOME, {16'd0, 16'd2000, 16'hF830});
		write_reg(REG_LEG2_HOME, {16'd0, 16'd0, 16'd2400});
		write_reg(REG_LEG3_HOME, {16'd0, 16'd0, 16'hF6A0});
		write_reg(REG_LEG4_HOME, {16'd0, 16'hF9C0, 16'd1600});
		write_reg(REG_LEG5_HOME, {16'd0, 16'hF830, 16'hF9C0});
		write_reg(REG_GAIT_DIMS, {16'hFC00, 16'd640, 16'd960});
		foreach (dir_tab2[r])
			send_point(dir_tab2[r].stp, dir_tab2[r].hdg, dir_tab2[r].sel);
		random_points(90, 40);
		wait_drained();

		// extremes: saturation, odd and tiny step counts
		write_reg(REG_GAIT_DIMS, {16'h7FFF, 16'hFFFF, 16'hFFFF});
		write_reg(REG_LEG0_HOME, {16'h7FFF, 16'h7FFF, 16'h7FFF});
		write_reg(REG_LEG3_HOME, {16'h8000, 16'h8000, 16'h8000});
		write_reg(REG_POINTS_PER_STEP, 11'd1);
		random_points(25, 4);
		wait_drained();
		write_reg(REG_GAIT_DIMS, {16'h8000, 16'hFFFF, 16'hFFFF});
		write_reg(REG_POINTS_PER_STEP, 11'd1024);
		random_points(40, 2047);
		wait_drained();
		write_reg(REG_POINTS_PER_STEP, 11'd2047);
		random_points(20, 2047);
		wait_drained();

		// random homes and dims, calm stretch first
		for (int ph = 0; ph < 4; ph++) begin
			calm = (ph == 0);
			for (int i = 0; i < 6; i++)
				write_reg(cfg_reg_t'(i), 48'({$urandom, $urandom}));
			write_reg(REG_GAIT_DIMS, 48'({$urandom, $urandom}));
			write_reg(REG_POINTS_PER_STEP, $urandom_range(2, 64));
			random_points(45, 70);
			wait_drained();
		end
		calm = 0;

		wait_drained();
		$display("covered %0d points and %0d leg beats over reset, typical, saturating",
			points_sent, beats_seen);
		$display("and random register settings with random stalls on both sides");
		if (errors == 0)
			$display("cycloid_gait_foot_trajectory_unit_tb: PASS");
		else
			$display("cycloid_gait_foot_trajectory_unit_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ----- cycloid_gait_foot_trajectory_unit.f -----
+incdir+rtl
rtl/cgft_pkg.sv
rtl/cgft_div.sv
rtl/cgft_sine.sv
rtl/cgft_scale.sv
rtl/cgft_legout.sv
rtl/cycloid_gait_foot_trajectory_unit.sv
sim/cycloid_gait_foot_trajectory_unit_tb.sv
